// ----- rtl/pff_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pff_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 16;
    localparam int GUARD        = 4;
    localparam int CW           = 36;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int D_W          = 28;

    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
    localparam logic [31:0] PUSH     = 32'(100 << FRAC_BITS);

    typedef enum logic [1:0] {
        OP_POS  = 2'd0,
        OP_GOAL = 2'd1,
        OP_OBST = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_ATT_RADIUS = 3'd0,
        CFG_ATT_SPREAD = 3'd1,
        CFG_ATT_GAIN   = 3'd2,
        CFG_REP_RADIUS = 3'd3,
        CFG_REP_SPREAD = 3'd4,
        CFG_REP_GAIN   = 3'd5,
        CFG_NEAR_TOL   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [22:0] att_radius;
        logic [22:0] att_spread;
        logic [16:0] att_gain;
        logic [22:0] rep_radius;
        logic [22:0] rep_spread;
        logic [16:0] rep_gain;
        logic [16:0] near_tol;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cor_ctl;

    typedef struct packed {
        logic busy;
    } t_cor_sts;

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_PUSH = 2'd1,
        K_ROT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_VEC    = 3'd1,
        S_DIST   = 3'd2,
        S_SCALE  = 3'd3,
        S_MAG    = 3'd4,
        S_RSTART = 3'd5,
        S_ROT    = 3'd6,
        S_ACC    = 3'd7
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/potential_field_force.sv -----
`timescale 1ns / 1ps
`default_nettype none
// potential field force engine: op 0 loads the robot position and clears the repulsive sums,
// op 1 takes a goal and sets the attractive force, op 2 adds one obstacle's repulsive force
// and, when tlast is set, emits both forces and the clip flag. forces are q16.16, points are
// q8.16. a position load needs no cordic pass; a goal or obstacle runs the shared cordic unit
// at one micro-rotation per cycle for its vectoring pass and, when a direction is needed, again
// for its rotation pass. the input is not ready while busy.
module potential_field_force (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [22:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [55:0]   s_axis_tdata,   // op[1:0], point_x[25:2], point_y[49:26], zeros
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [127:0]       m_axis_tdata,   // attract_x, attract_y, repulse_x, repulse_y
    output logic               m_axis_tuser    // saturated
);
    import pff_pkg::*;

    t_cfg      cfg;
    t_cor_ctl  cor_ctl;
    t_cor_sts  cor_sts;
    logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;

    pff_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pff_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x0    (cor_x0),
        .i_y0    (cor_y0),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_sts   (cor_sts)
    );

    t_state r_state, n_state;
    t_op    r_op, in_op;
    logic   r_last, r_flip, r_dx_neg, r_dx_zero, r_dy_neg, r_dy_zero;
    t_kind  r_kind, n_kind;
    logic signed [23:0] r_robot_x, r_robot_y;
    logic signed [31:0] r_att_x, r_att_y, r_rep_x, r_rep_y;
    logic               r_clip;
    logic [63:0]        r_prod;
    logic [D_W-1:0]     r_d;
    logic [127:0]       r_out_data;
    logic               r_out_sat, r_out_valid;

    logic               accept;
    logic signed [23:0] px, py;
    logic signed [24:0] dx, dy;
    logic signed [CW-1:0] dxe, dye;
    logic               flip;

    assign in_op  = t_op'(s_axis_tdata[1:0]);
    assign px     = s_axis_tdata[25:2];
    assign py     = s_axis_tdata[49:26];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign dx     = {px[23], px} - {r_robot_x[23], r_robot_x};
    assign dy     = {py[23], py} - {r_robot_y[23], r_robot_y};
    assign dxe    = {{(CW-25){dx[24]}}, dx};
    assign dye    = {{(CW-25){dy[24]}}, dy};
    assign flip   = dx[24];

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [23:0] near_lim, far_lim;
    logic [D_W-1:0] diff;
    logic [16:0] gain;
    logic        is_goal;

    assign is_goal = (r_op == OP_GOAL);

    always_comb begin
        near_lim = is_goal ? ({1'b0, cfg.att_radius} + {7'd0, cfg.near_tol})
                           : ({1'b0, cfg.rep_radius} + {7'd0, cfg.near_tol});
        far_lim  = is_goal ? ({1'b0, cfg.att_spread} + {1'b0, cfg.att_radius})
                           : ({1'b0, cfg.rep_spread} + {1'b0, cfg.rep_radius});
        gain     = is_goal ? cfg.att_gain : cfg.rep_gain;
        if (r_d < D_W'(near_lim)) begin
            n_kind = is_goal ? K_ZERO : K_PUSH;
            diff   = '0;
        end else if (r_d <= D_W'(far_lim)) begin
            n_kind = K_ROT;
            diff   = is_goal ? (r_d - D_W'(cfg.att_radius)) : (D_W'(far_lim) - r_d);
        end else begin
            n_kind = is_goal ? K_ROT : K_ZERO;
            diff   = D_W'(cfg.att_spread);
        end
    end

    always_comb begin
        case (r_state)
            S_VEC: begin
                mul_a = cor_x[CW-1] ? 32'd0 : cor_x[31:0];
                mul_b = INV_GAIN;
            end
            S_SCALE: begin
                mul_a = {15'd0, gain};
                mul_b = {{(32-D_W){1'b0}}, diff};
            end
            S_MAG: begin
                mul_a = {r_prod[FRAC_BITS +: 32-GUARD], {GUARD{1'b0}}};
                mul_b = INV_GAIN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // force of the current point
    logic signed [CW-1:0] xr, yr, xsh, ysh;
    logic signed [32:0]   fx, fy, rot_x, rot_y;

    always_comb begin
        xr    = r_flip ? -cor_x : cor_x;
        yr    = r_flip ? -cor_y : cor_y;
        xsh   = xr >>> GUARD;
        ysh   = yr >>> GUARD;
        rot_x = {xsh[31], xsh[31:0]};
        rot_y = {ysh[31], ysh[31:0]};
        case (r_kind)
            K_PUSH: begin
                if (r_dx_zero && r_dy_zero) begin
                    fx = -$signed({1'b0, PUSH});
                end else if (r_dx_neg) begin
                    fx = $signed({1'b0, PUSH});
                end else if (r_dx_zero) begin
                    fx = '0;
                end else begin
                    fx = -$signed({1'b0, PUSH});
                end
                if (r_dy_neg) begin
                    fy = $signed({1'b0, PUSH});
                end else if (r_dy_zero) begin
                    fy = '0;
                end else begin
                    fy = -$signed({1'b0, PUSH});
                end
            end
            K_ROT: begin
                fx = is_goal ? rot_x : -rot_x;
                fy = is_goal ? rot_y : -rot_y;
            end
            default: begin
                fx = '0;
                fy = '0;
            end
        endcase
    end

    logic signed [33:0] sum_x, sum_y;
    logic signed [31:0] n_rep_x, n_rep_y;
    logic               clip_x, clip_y;

    always_comb begin
        sum_x  = 34'(r_rep_x) + 34'(fx);
        sum_y  = 34'(r_rep_y) + 34'(fy);
        clip_x = (sum_x > 34'sd2147483647) || (sum_x < -34'sd2147483648);
        clip_y = (sum_y > 34'sd2147483647) || (sum_y < -34'sd2147483648);
        n_rep_x = clip_x ? (sum_x[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_x[31:0];
        n_rep_y = clip_y ? (sum_y[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_y[31:0];
    end

    logic want_out, out_free;
    assign want_out = (r_op == OP_OBST) && r_last;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept && (in_op == OP_GOAL || in_op == OP_OBST)) n_state = S_VEC;
            S_VEC:    if (!cor_sts.busy) n_state = S_DIST;
            S_DIST:   n_state = S_SCALE;
            S_SCALE:  n_state = (n_kind == K_ROT) ? S_MAG : S_ACC;
            S_MAG:    n_state = S_RSTART;
            S_RSTART: n_state = S_ROT;
            S_ROT:    if (!cor_sts.busy) n_state = S_ACC;
            S_ACC:    if (!want_out || out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready  = 1'b0;
        cor_ctl.start  = 1'b0;
        cor_ctl.rotate = 1'b0;
        cor_x0         = (flip ? -dxe : dxe) <<< GUARD;
        cor_y0         = (flip ? -dye : dye) <<< GUARD;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                cor_ctl.start = s_axis_tvalid && (in_op == OP_GOAL || in_op == OP_OBST);
            end
            S_RSTART: begin
                cor_ctl.start  = 1'b1;
                cor_ctl.rotate = 1'b1;
                cor_x0         = {{(CW-32){1'b0}}, r_prod[63:32]};
                cor_y0         = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_robot_x <= '0;
            r_robot_y <= '0;
            r_att_x   <= '0;
            r_att_y   <= '0;
            r_rep_x   <= '0;
            r_rep_y   <= '0;
            r_clip    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC && want_out && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && in_op == OP_POS) begin
                r_robot_x <= px;
                r_robot_y <= py;
                r_rep_x   <= '0;
                r_rep_y   <= '0;
                r_clip    <= 1'b0;
            end
            if (r_state == S_ACC && (!want_out || out_free)) begin
                if (is_goal) begin
                    r_att_x <= fx[31:0];
                    r_att_y <= fy[31:0];
                end else begin
                    r_rep_x <= n_rep_x;
                    r_rep_y <= n_rep_y;
                    r_clip  <= r_clip || clip_x || clip_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= in_op;
            r_last    <= s_axis_tlast;
            r_flip    <= flip;
            r_dx_neg  <= dx[24];
            r_dx_zero <= (dx == '0);
            r_dy_neg  <= dy[24];
            r_dy_zero <= (dy == '0);
        end
        if ((r_state == S_VEC && !cor_sts.busy) || r_state == S_SCALE || r_state == S_MAG) begin
            r_prod <= mul_p;
        end
        if (r_state == S_DIST) begin
            r_d <= r_prod[63:64-D_W];
        end
        if (r_state == S_SCALE) begin
            r_kind <= n_kind;
        end
        if (r_state == S_ACC && want_out && out_free) begin
            r_out_data <= {n_rep_y, n_rep_x, r_att_y, r_att_x};
            r_out_sat  <= r_clip || clip_x || clip_y;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

`ifndef SYNTHESIS
    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_ACC))
        else $error("result raised outside accumulate step");
    a_clip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clip) |-> $past(accept && in_op == OP_POS))
        else $error("clip flag cleared without position load");
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_sts.busy |-> !s_axis_tready)
        else $error("input ready while cordic busy");
`endif

endmodule
`default_nettype wire

// ----- rtl/pff_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pff_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [22:0]   i_cfg_data,
    output pff_pkg::t_cfg      o_cfg
);
    import pff_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.att_radius <= 23'd655;
            r_cfg.att_spread <= 23'd229376;
            r_cfg.att_gain   <= 17'd3277;
            r_cfg.rep_radius <= 23'd22938;
            r_cfg.rep_spread <= 23'd45875;
            r_cfg.rep_gain   <= 17'd655;
            r_cfg.near_tol   <= 17'd655;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATT_RADIUS: r_cfg.att_radius <= i_cfg_data;
                CFG_ATT_SPREAD: r_cfg.att_spread <= i_cfg_data;
                CFG_ATT_GAIN:   r_cfg.att_gain   <= i_cfg_data[16:0];
                CFG_REP_RADIUS: r_cfg.rep_radius <= i_cfg_data;
                CFG_REP_SPREAD: r_cfg.rep_spread <= i_cfg_data;
                CFG_REP_GAIN:   r_cfg.rep_gain   <= i_cfg_data[16:0];
                CFG_NEAR_TOL:   r_cfg.near_tol   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pff_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pff_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pff_pkg::t_cor_ctl                 i_ctl,
    input  wire logic signed [pff_pkg::CW-1:0]     i_x0,
    input  wire logic signed [pff_pkg::CW-1:0]     i_y0,
    output logic signed [pff_pkg::CW-1:0]          o_x,
    output logic signed [pff_pkg::CW-1:0]          o_y,
    output pff_pkg::t_cor_sts                      o_sts
);
    import pff_pkg::*;

    logic signed [CW-1:0]     r_x, r_y, n_x, n_y;
    logic [CORDIC_STEPS-1:0]  r_dirs;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_rot;
    logic signed [CW-1:0]     xs, ys;
    logic                     sub;

    always_comb begin
        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;
        sub = r_rot ? !r_dirs[r_cnt] : (r_y >= 0);
        if (sub) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rot  <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rot  <= i_ctl.rotate;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= i_x0;
            r_y <= i_y0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            if (!r_rot) begin
                r_dirs[r_cnt] <= sub;
            end
        end
    end

    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_sts.busy = r_busy;

`ifndef SYNTHESIS
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(i_ctl.start))
        else $error("cordic started without request");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_ctl.start && r_cnt == CNT_W'(CORDIC_STEPS - 1) |=> !r_busy)
        else $error("cordic ran past its last step");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < CNT_W'(CORDIC_STEPS)))
        else $error("cordic step count out of range");
`endif

endmodule
`default_nettype wire
